### src/qcld_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quantized code lookup distance: shared package
// Fixed field widths, command and register codes, and the sequencer state
// type used by the lookup distance block.
// ----------------------------------------------------------------------------
package qcld_pkg;

   // Each dictionary holds this many codewords.
   localparam int BUCKETS = 256;

   // Port widths fixed by the item and result formats.
   localparam int CMD_W   = 2;
   localparam int CODE_W  = 8;
   localparam int ROW_W   = 9;
   localparam int VALUE_W = 32;
   localparam int DIST_W  = 34;

   // Configuration port.
   localparam int ADDR_W     = 3;
   localparam int DATA_W     = 32;
   localparam int PARTS_W    = 2;
   localparam int REG_IDX_W  = 1;
   localparam logic [PARTS_W-1:0] PARTS_RESET = 2'd2;

   // Register indexes.
   typedef enum logic [REG_IDX_W-1:0] {
      REG_PARTS_IN_USE = 1'b0
   } reg_idx_type;

   // Item commands; the remaining code is ignored.
   typedef enum logic [CMD_W-1:0] {
      CMD_MATRIX   = 2'd0,
      CMD_QUERY    = 2'd1,
      CMD_DATABASE = 2'd2
   } cmd_type;

   // Query row walk sequencer.
   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_WALK  = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

endpackage

### src/qcld_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic dual-port RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module qcld_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/quantized_code_lookup_distance.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quantized code lookup distance
// Pair matrix store, per-query lookup table and running distance sum for
// byte-coded quantized vectors: values signed Q16.16, distances signed Q18.16.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken when start is high and busy is low. A matrix write
//   stores one word into the pair matrix. A database code byte reads one
//   lookup table entry and adds it to the running sum; these bytes stream
//   at one per cycle while busy is low. The byte of the last part in use
//   gives a distance beat on rsp_distance with rsp_valid high for one
//   cycle, after the registered table read and result stage, and clears
//   the sum. A query code byte walks one pair matrix row, one entry per
//   cycle, so busy stays high for the walk over the effective part count
//   times 256 entries and the drain state for the last table write; the
//   single read port of each memory sets that rate. The configuration
//   register parts_in_use sits at byte address 0 of the APB-style port and
//   must be written only while the block is idle; the block itself does
//   not enforce this. Reset clears the sum, the pipeline and the sequencer
//   and sets parts_in_use to 2; neither memory is cleared. Result beats
//   cannot be held off, so there is no backpressure path.
// ----------------------------------------------------------------------------
module quantized_code_lookup_distance #(
   parameter int NUM_PARTS = 2
) (
   input  logic                          clock,
   input  logic                          reset,
   // item channel
   input  logic                          start,
   output logic                          busy,
   input  logic [qcld_pkg::CMD_W-1:0]    req_command,
   input  logic                          req_part,
   input  logic [qcld_pkg::CODE_W-1:0]   req_code,
   input  logic [qcld_pkg::ROW_W-1:0]    req_row,
   input  logic [qcld_pkg::ROW_W-1:0]    req_column,
   input  logic signed [qcld_pkg::VALUE_W-1:0] req_value,
   // result channel
   output logic                          rsp_valid,
   output logic signed [qcld_pkg::DIST_W-1:0]  rsp_distance,
   // configuration port
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [qcld_pkg::ADDR_W-1:0]   paddr,
   input  logic [qcld_pkg::DATA_W-1:0]   pwdata,
   output logic [qcld_pkg::DATA_W-1:0]   prdata,
   output logic                          pready
);

   import qcld_pkg::*;

   localparam int SIDE      = NUM_PARTS * BUCKETS;
   localparam int IDX_W     = $clog2(SIDE);
   localparam int MAT_DEPTH = SIDE * SIDE;
   localparam int MAT_AW    = $clog2(MAT_DEPTH);
   // Table entries and the sum are kept modulo the distance width, since
   // repeated later-part queries and stray partial sums can grow without bound.
   localparam int QT_W      = DIST_W;
   localparam int SUM_W     = DIST_W;
   localparam int USED_W    = $clog2(NUM_PARTS + 1);

   // Registers.
   logic [PARTS_W-1:0]      parts_ff, parts_in;
   state_type               state_ff, state_in;
   logic [IDX_W-1:0]        walk_idx_ff, walk_idx_in;
   logic [IDX_W-1:0]        last_idx_ff, last_idx_in;
   logic [MAT_AW-1:0]       mat_addr_ff, mat_addr_in;
   logic                    first_ff, first_in;
   logic                    wr_valid_ff, wr_valid_in;
   logic [IDX_W-1:0]        wr_idx_ff, wr_idx_in;
   logic                    db_valid_ff, db_valid_in;
   logic                    db_last_ff, db_last_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [DIST_W-1:0] rsp_distance_ff, rsp_distance_in;

   // Decode and memory signals.
   logic                    accept;
   logic                    cfg_write;
   logic [USED_W-1:0]       used;
   logic                    part_ok;
   logic                    part_last;
   logic                    row_ok;
   logic                    do_write;
   logic                    do_query;
   logic                    do_db;
   logic [IDX_W-1:0]        sel_idx;
   logic [MAT_AW-1:0]       mat_wr_addr;
   logic [MAT_AW-1:0]       mat_base;
   logic [VALUE_W-1:0]      mat_rd_data;
   logic                    walking;
   logic                    qt_rd_en;
   logic [IDX_W-1:0]        qt_rd_addr;
   logic [QT_W-1:0]         qt_rd_data;
   logic signed [QT_W-1:0]  qt_word;
   logic signed [QT_W-1:0]  qt_new;
   logic signed [SUM_W-1:0] sum_next;

   // Configuration port: one register, always ready.
   assign pready    = 1'b1;
   assign cfg_write = psel & penable & pwrite & pready;

   always_comb begin
      parts_in = parts_ff;
      if (cfg_write && (paddr[2] == REG_PARTS_IN_USE)) begin
         parts_in = pwdata[PARTS_W-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == REG_PARTS_IN_USE) begin
         prdata = {{(DATA_W-PARTS_W){1'b0}}, parts_ff};
      end
   end

   // Effective number of parts: zero acts as one, large values saturate.
   always_comb begin
      if (parts_ff == '0) begin
         used = USED_W'(1);
      end else if (32'(parts_ff) > NUM_PARTS) begin
         used = USED_W'(NUM_PARTS);
      end else begin
         used = USED_W'(parts_ff);
      end
   end

   // Item decode.
   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start & ~busy;
   assign part_ok   = (32'(req_part) < 32'(used));
   assign part_last = (32'(req_part) == (32'(used) - 1));
   assign row_ok    = (32'(req_row) < SIDE) && (32'(req_column) < SIDE);
   assign sel_idx   = IDX_W'(32'(req_part) * BUCKETS + 32'(req_code));
   assign mat_base  = MAT_AW'(sel_idx) * MAT_AW'(SIDE);
   assign mat_wr_addr = MAT_AW'(req_row) * MAT_AW'(SIDE) + MAT_AW'(req_column);

   always_comb begin
      do_write = 1'b0;
      do_query = 1'b0;
      do_db    = 1'b0;
      case (cmd_type'(req_command))
         CMD_MATRIX: begin
            do_write = accept & row_ok;
         end
         CMD_QUERY: begin
            do_query = accept & part_ok;
         end
         CMD_DATABASE: begin
            do_db = accept & part_ok;
         end
         default: begin
            do_write = 1'b0;
         end
      endcase
   end

   // Query row walk sequencer: one matrix entry per cycle.
   assign walking = (state_ff == ST_WALK);

   always_comb begin
      state_in    = state_ff;
      walk_idx_in = walk_idx_ff;
      last_idx_in = last_idx_ff;
      mat_addr_in = mat_addr_ff;
      first_in    = first_ff;
      case (state_ff)
         ST_IDLE: begin
            if (do_query) begin
               state_in    = ST_WALK;
               walk_idx_in = '0;
               last_idx_in = IDX_W'(32'(used) * BUCKETS - 1);
               mat_addr_in = mat_base;
               first_in    = (req_part == 1'b0);
            end
         end
         ST_WALK: begin
            walk_idx_in = walk_idx_ff + IDX_W'(1);
            mat_addr_in = mat_addr_ff + MAT_AW'(1);
            if (walk_idx_ff == last_idx_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Write stage of the walk: overwrite on the first part, else accumulate.
   assign wr_valid_in = walking;
   assign wr_idx_in   = walk_idx_ff;
   assign qt_word     = QT_W'(signed'(mat_rd_data));
   assign qt_new      = first_ff ? qt_word : (signed'(qt_rd_data) + qt_word);

   // Lookup table read port is shared between the walk and database bytes.
   assign qt_rd_en   = walking | do_db;
   assign qt_rd_addr = walking ? walk_idx_ff : sel_idx;

   // Database byte: add the looked-up entry in the cycle after the read.
   assign db_valid_in = do_db;
   assign db_last_in  = part_last;
   assign sum_next    = sum_ff + SUM_W'(signed'(qt_rd_data));

   always_comb begin
      sum_in          = sum_ff;
      rsp_valid_in    = 1'b0;
      rsp_distance_in = rsp_distance_ff;
      if (db_valid_ff) begin
         if (db_last_ff) begin
            sum_in          = '0;
            rsp_valid_in    = 1'b1;
            rsp_distance_in = DIST_W'(sum_next);
         end else begin
            sum_in = sum_next;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         parts_ff     <= PARTS_RESET;
         state_ff     <= ST_IDLE;
         wr_valid_ff  <= 1'b0;
         db_valid_ff  <= 1'b0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         parts_ff     <= parts_in;
         state_ff     <= state_in;
         wr_valid_ff  <= wr_valid_in;
         db_valid_ff  <= db_valid_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      walk_idx_ff     <= walk_idx_in;
      last_idx_ff     <= last_idx_in;
      mat_addr_ff     <= mat_addr_in;
      first_ff        <= first_in;
      wr_idx_ff       <= wr_idx_in;
      db_last_ff      <= db_last_in;
      rsp_distance_ff <= rsp_distance_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_distance = rsp_distance_ff;

   // Pair matrix store.
   qcld_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (MAT_DEPTH)
   ) u_pair_matrix (
      .clock   (clock),
      .wr_en   (do_write),
      .wr_addr (mat_wr_addr),
      .wr_data (req_value),
      .rd_en   (walking),
      .rd_addr (mat_addr_ff),
      .rd_data (mat_rd_data)
   );

   // Per-query lookup table.
   qcld_ram #(
      .WIDTH (QT_W),
      .DEPTH (SIDE)
   ) u_query_table (
      .clock   (clock),
      .wr_en   (wr_valid_ff),
      .wr_addr (wr_idx_ff),
      .wr_data (qt_new),
      .rd_en   (qt_rd_en),
      .rd_addr (qt_rd_addr),
      .rd_data (qt_rd_data)
   );

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quantized code lookup distance: self-checking testbench
// Fills rows of the pair matrix and then streams query and database code
// bytes with random gaps. Every accepted beat is applied to a behavioural
// copy of the matrix, the per-query table and the running sum. Each distance
// beat is compared with the oldest predicted distance. The parts register is
// written between phases, only once the block has gone quiet.
// ----------------------------------------------------------------------------
module testbench;
   import qcld_pkg::*;

   localparam int NUM_PARTS    = 2;
   localparam int SIDE         = NUM_PARTS * BUCKETS;
   localparam int SPARE_REG    = 1;
   localparam int SETTLE       = 8;
   localparam int QUIET_LIMIT  = 4000;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef struct {
      bit [CMD_W-1:0]          command;
      bit                      part;
      bit [CODE_W-1:0]         code;
      bit [ROW_W-1:0]          row;
      bit [ROW_W-1:0]          column;
      bit signed [VALUE_W-1:0] value;
      int unsigned             gap;
      bit                      hold;
   } lookup_item_type;

   // Clock, reset and block inputs, all known from time zero.
   logic clock;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [CMD_W-1:0] req_command = '0;
   logic req_part = 1'b0;
   logic [CODE_W-1:0] req_code = '0;
   logic [ROW_W-1:0] req_row = '0;
   logic [ROW_W-1:0] req_column = '0;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic rsp_valid;
   logic signed [DIST_W-1:0] rsp_distance;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [ADDR_W-1:0] paddr = '0;
   logic [DATA_W-1:0] pwdata = '0;
   logic [DATA_W-1:0] prdata;
   logic pready;

   // Behavioural copy of the block state.
   bit signed [VALUE_W-1:0]  matrix_words [SIDE*SIDE];
   bit signed [DIST_W-1:0]   lookup_table [SIDE];
   bit signed [DIST_W-1:0]   distance_sum = '0;
   logic [PARTS_W-1:0]       parts_setting = PARTS_RESET;
   bit signed [DIST_W-1:0]   expected_distances [$];

   // Stimulus bookkeeping: which rows are complete and which table halves hold data.
   lookup_item_type pending_items [$];
   lookup_item_type on_bus;
   bit [CODE_W-1:0] full_codes_lo [$];
   bit [CODE_W-1:0] full_codes_hi [$];
   bit           table_lo = 1'b0;
   bit           table_hi = 1'b0;
   int unsigned  burst_left = 0;
   int unsigned  fill_words = 0;
   int unsigned  generated_count = 0;
   int unsigned  accepted_count = 0;
   int unsigned  idle_count = 0;

   // Run statistics.
   int unsigned matrix_count = 0;
   int unsigned query_count = 0;
   int unsigned database_count = 0;
   int unsigned distance_count = 0;
   int unsigned mismatch_count = 0;

   quantized_code_lookup_distance #(
      .NUM_PARTS (NUM_PARTS)
   ) u_top (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_command  (req_command),
      .req_part     (req_part),
      .req_code     (req_code),
      .req_row      (req_row),
      .req_column   (req_column),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_distance (rsp_distance),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   // A parts setting of zero behaves as one; anything above the build size is clamped.
   function automatic int unsigned effective_parts(input logic [PARTS_W-1:0] setting);
      if (setting == 0) return 1;
      if (setting > NUM_PARTS) return NUM_PARTS;
      return setting;
   endfunction

   // Applies one accepted beat to the state copy and predicts any distance it releases.
   function automatic void track_lookup_item(input lookup_item_type it);
      int unsigned used;
      int unsigned entry;
      bit signed [VALUE_W-1:0] word;
      used = effective_parts(parts_setting);
      entry = it.part * BUCKETS + it.code;
      case (it.command)
         CMD_MATRIX: begin
            matrix_words[it.row * SIDE + it.column] = it.value;
            matrix_count++;
         end
         CMD_QUERY: begin
            query_count++;
            if (it.part < used) begin
               // The first part overwrites the table, later parts add onto it.
               for (int unsigned j = 0; j < used * BUCKETS; j++) begin
                  word = matrix_words[entry * SIDE + j];
                  if (it.part == 0) lookup_table[j] = word;
                  else lookup_table[j] = lookup_table[j] + word;
               end
            end
         end
         CMD_DATABASE: begin
            database_count++;
            if (it.part < used) begin
               distance_sum = distance_sum + lookup_table[entry];
               if (it.part == used - 1) begin
                  expected_distances.push_back(distance_sum);
                  distance_sum = '0;
               end
            end
         end
         default: ;
      endcase
   endfunction

   // Idle cycles before each beat, with occasional back-to-back stretches.
   function automatic int unsigned draw_gap();
      if (burst_left != 0) begin
         burst_left--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) burst_left = $urandom_range(8, 40);
      return $urandom_range(0, 14);
   endfunction

   function automatic lookup_item_type random_item(input logic [CMD_W-1:0] command);
      lookup_item_type item;
      item.command = command;
      item.part    = $urandom_range(0, 1);
      item.code    = $urandom_range(0, BUCKETS - 1);
      item.row     = $urandom_range(0, SIDE - 1);
      item.column  = $urandom_range(0, SIDE - 1);
      item.value   = $urandom();
      item.gap     = draw_gap();
      item.hold    = ($urandom_range(0, 299) == 0);
      return item;
   endfunction

   task automatic queue_item(input lookup_item_type item);
      pending_items.push_back(item);
      generated_count++;
   endtask

   task automatic queue_matrix(input int unsigned row, input int unsigned column,
                               input logic [VALUE_W-1:0] value);
      lookup_item_type item;
      item = random_item(CMD_MATRIX);
      item.row    = ROW_W'(row);
      item.column = ROW_W'(column);
      item.value  = value;
      queue_item(item);
   endtask

   // Queues a query or database byte and notes which table halves a query writes.
   task automatic queue_byte(input logic [CMD_W-1:0] command, input bit part,
                             input int unsigned code);
      lookup_item_type item;
      int unsigned used;
      used = effective_parts(parts_setting);
      item = random_item(command);
      item.part = part;
      item.code = CODE_W'(code);
      if (command == CMD_QUERY && part == 0) begin
         table_lo = 1'b1;
         if (used > 1) table_hi = 1'b1;
      end
      queue_item(item);
   endtask

   task automatic fill_row(input int unsigned row);
      for (int unsigned col = 0; col < SIDE; col++) queue_matrix(row, col, $urandom());
      if (row < BUCKETS) full_codes_lo.push_back(CODE_W'(row));
      else full_codes_hi.push_back(CODE_W'(row - BUCKETS));
      fill_words += SIDE;
   endtask

   // Only codes whose matrix row is completely written may be queried.
   function automatic int unsigned pick_code(input bit part);
      if (part == 0) return full_codes_lo[$urandom_range(0, full_codes_lo.size() - 1)];
      return full_codes_hi[$urandom_range(0, full_codes_hi.size() - 1)];
   endfunction

   task automatic query_vector();
      int unsigned used;
      used = effective_parts(parts_setting);
      if (used > 1 && table_lo && table_hi && $urandom_range(0, 4) == 0) begin
         // A later part on its own adds onto whatever the table holds.
         queue_byte(CMD_QUERY, 1'b1, pick_code(1'b1));
         if ($urandom_range(0, 1) == 1) queue_byte(CMD_QUERY, 1'b0, pick_code(1'b0));
      end else begin
         queue_byte(CMD_QUERY, 1'b0, pick_code(1'b0));
         if (used > 1) queue_byte(CMD_QUERY, 1'b1, pick_code(1'b1));
      end
   endtask

   task automatic database_vector();
      int unsigned used;
      used = effective_parts(parts_setting);
      if (!table_lo || (used > 1 && !table_hi)) query_vector();
      if (used > 1 && $urandom_range(0, 6) == 0) begin
         // Last part first: its distance goes out and the first part stays summed.
         queue_byte(CMD_DATABASE, 1'b1, $urandom_range(0, BUCKETS - 1));
         queue_byte(CMD_DATABASE, 1'b0, $urandom_range(0, BUCKETS - 1));
      end else begin
         for (int unsigned p = 0; p < used; p++)
            queue_byte(CMD_DATABASE, p[0], $urandom_range(0, BUCKETS - 1));
      end
   endtask

   task automatic random_step();
      int unsigned pick;
      int unsigned used;
      lookup_item_type item;
      pick = $urandom_range(0, 99);
      used = effective_parts(parts_setting);
      if (pick < 12) begin
         queue_matrix($urandom_range(0, SIDE - 1), $urandom_range(0, SIDE - 1), $urandom());
      end else if (pick < 27) begin
         query_vector();
      end else if (pick < 85) begin
         repeat ($urandom_range(1, 4)) database_vector();
      end else begin
         // Noise: unknown commands, bytes of parts not in use, stray partial sums, random matrix words.
         case ($urandom_range(0, 2))
            0: begin
               item = random_item(CMD_UNUSED);
               queue_item(item);
            end
            1: begin
               if (used == 1)
                  queue_byte($urandom_range(0, 1) ? CMD_QUERY : CMD_DATABASE, 1'b1,
                             $urandom_range(0, BUCKETS - 1));
               else if (table_lo)
                  queue_byte(CMD_DATABASE, 1'b0, $urandom_range(0, BUCKETS - 1));
            end
            default: queue_matrix($urandom_range(0, SIDE - 1), $urandom_range(0, SIDE - 1),
                                  $urandom());
         endcase
      end
   endtask

   task automatic run_random(input int unsigned count);
      int unsigned target;
      target = generated_count - fill_words + count;
      while (generated_count - fill_words < target) random_step();
   endtask

   task automatic csr_write(input int unsigned index, input logic [DATA_W-1:0] data);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_W'(4 * index);
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (index == REG_PARTS_IN_USE) parts_setting = data[PARTS_W-1:0];
   endtask

   task automatic csr_read(input int unsigned index, output logic [DATA_W-1:0] data);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= ADDR_W'(4 * index);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      data = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic check_parts_readback();
      logic [DATA_W-1:0] got;
      csr_read(REG_PARTS_IN_USE, got);
      if (got !== DATA_W'(parts_setting))
         report_mismatch($sformatf("parts register reads %0d, expected %0d",
                                   got, parts_setting));
   endtask

   // Waits until every beat is taken, every distance is back and the row walk is over.
   task automatic wait_until_quiet();
      int unsigned waited;
      waited = 0;
      do @(negedge clock); while (accepted_count != generated_count);
      while ((expected_distances.size() != 0 || busy !== 1'b0) && waited < QUIET_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (SETTLE) @(posedge clock);
      if (expected_distances.size() != 0) begin
         report_mismatch($sformatf("%0d distances never arrived", expected_distances.size()));
         expected_distances.delete();
      end
   endtask

   // Driver: presents queued beats after their idle gap and holds them while busy.
   always @(posedge clock) begin
      bit taken;
      taken = start && !busy;
      if (reset) begin
         start      <= 1'b0;
         idle_count <= 0;
      end else begin
         if (taken) begin
            track_lookup_item(on_bus);
            accepted_count++;
         end
         if (start && !taken) begin
            // Beat still waiting for the block; keep it on the bus.
         end else if (pending_items.size() != 0 && idle_count < pending_items[0].gap) begin
            start      <= 1'b0;
            idle_count <= idle_count + 1;
         end else if (pending_items.size() != 0 &&
                      (!pending_items[0].hold || expected_distances.size() == 0)) begin
            on_bus = pending_items.pop_front();
            req_command <= on_bus.command;
            req_part    <= on_bus.part;
            req_code    <= on_bus.code;
            req_row     <= on_bus.row;
            req_column  <= on_bus.column;
            req_value   <= on_bus.value;
            start       <= 1'b1;
            idle_count  <= 0;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: every distance beat must match the oldest prediction.
   always @(posedge clock) begin
      bit signed [DIST_W-1:0] want;
      if (!reset && rsp_valid !== 1'b0) begin
         if (expected_distances.size() == 0) begin
            report_mismatch($sformatf("distance %0d with none expected", rsp_distance));
         end else begin
            want = expected_distances.pop_front();
            if (rsp_distance !== want)
               report_mismatch($sformatf("distance %0d, expected %0d", rsp_distance, want));
            distance_count++;
         end
      end
   end

   initial begin
      #16_000_000;
      $display("quantized_code_lookup_distance regression: fail");
      $finish;
   end

   initial begin
      logic [PARTS_W-1:0] phase_parts [4] = '{2'd1, 2'd0, 2'd3, 2'd2};
      int unsigned phase_items [4] = '{80, 80, 80, 60};
      logic [VALUE_W-1:0] extreme;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      check_parts_readback();

      // Complete rows for the lowest code of the first part and the highest of the last.
      fill_row(0);
      fill_row(SIDE - 1);

      // Directed beats: unknown command, extreme codes, bytes out of order.
      queue_item(random_item(CMD_UNUSED));
      queue_byte(CMD_QUERY, 1'b0, 0);
      queue_byte(CMD_QUERY, 1'b1, BUCKETS - 1);
      queue_byte(CMD_DATABASE, 1'b0, 0);
      queue_byte(CMD_DATABASE, 1'b1, BUCKETS - 1);
      queue_byte(CMD_DATABASE, 1'b1, 0);
      queue_byte(CMD_DATABASE, 1'b0, BUCKETS - 1);
      queue_byte(CMD_DATABASE, 1'b1, BUCKETS / 2);
      pending_items[pending_items.size() - 1].hold = 1'b1;

      // Largest and smallest sums: four extreme words meet in one distance.
      for (int k = 0; k < 2; k++) begin
         extreme = (k == 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
         queue_matrix(0, 0, extreme);
         queue_matrix(0, SIDE - 1, extreme);
         queue_matrix(SIDE - 1, 0, extreme);
         queue_matrix(SIDE - 1, SIDE - 1, extreme);
         queue_byte(CMD_QUERY, 1'b0, 0);
         queue_byte(CMD_QUERY, 1'b1, BUCKETS - 1);
         queue_byte(CMD_DATABASE, 1'b0, 0);
         queue_byte(CMD_DATABASE, 1'b1, BUCKETS - 1);
      end
      run_random(200);

      // Further phases with the parts register at both extremes and in between.
      for (int p = 0; p < 4; p++) begin
         wait_until_quiet();
         csr_write(REG_PARTS_IN_USE, ($urandom() & ~32'h3) | DATA_W'(phase_parts[p]));
         if (phase_parts[p] == 0) csr_write(SPARE_REG, $urandom());
         check_parts_readback();
         run_random(phase_items[p]);
      end
      wait_until_quiet();

      $display("Run covered %0d matrix words, %0d query bytes and %0d database bytes.",
               matrix_count, query_count, database_count);
      $display("%0d distances checked over parts settings 2, 1, 0, 3 and 2; %0d mismatches.",
               distance_count, mismatch_count);
      if (mismatch_count == 0) begin
         $display("quantized_code_lookup_distance regression: pass");
      end else begin
         $display("quantized_code_lookup_distance regression: fail");
      end
      $finish;
   end

endmodule
